// File: src/mbm_pkg.sv
// Shared types, codes and helper functions of the Modbus RTU poll-and-write master.
package mbm_pkg;

   typedef logic [1:0]  command_type;
   typedef logic [1:0]  kind_type;
   typedef logic [15:0] word_type;
   typedef logic [7:0]  byte_type;
   typedef logic [5:0]  count_type;
   typedef logic [2:0]  reg_index_type;
   typedef logic [3:0]  step_type;

   localparam command_type CMD_READ  = 2'd0;
   localparam command_type CMD_WRITE = 2'd1;
   localparam command_type CMD_RX    = 2'd2;

   localparam kind_type KIND_TX   = 2'd0;
   localparam kind_type KIND_WORD = 2'd1;
   localparam kind_type KIND_ACK  = 2'd2;

   localparam reg_index_type REG_SLAVE_ADDRESS = 3'd0;
   localparam reg_index_type REG_READ_START    = 3'd1;
   localparam reg_index_type REG_READ_COUNT    = 3'd2;
   localparam reg_index_type REG_WRITE_START   = 3'd3;
   localparam reg_index_type REG_WRITE_COUNT   = 3'd4;

   localparam byte_type  FN_READ   = 8'h03;
   localparam byte_type  FN_WRITE  = 8'h10;
   localparam count_type MAX_WORDS = 6'd60;
   localparam word_type  CRC_INIT  = 16'hFFFF;
   localparam word_type  CRC_POLY  = 16'hA001;
   localparam byte_type  ACK_LENGTH = 8'd7;

   localparam step_type STEP_ADDR     = 4'd0;
   localparam step_type STEP_FUNC     = 4'd1;
   localparam step_type STEP_START_HI = 4'd2;
   localparam step_type STEP_START_LO = 4'd3;
   localparam step_type STEP_CNT_HI   = 4'd4;
   localparam step_type STEP_CNT_LO   = 4'd5;
   localparam step_type STEP_BYTES    = 4'd6;
   localparam step_type STEP_DATA_HI  = 4'd7;
   localparam step_type STEP_DATA_LO  = 4'd8;
   localparam step_type STEP_CRC_LO   = 4'd9;
   localparam step_type STEP_CRC_HI   = 4'd10;

   function automatic count_type sat_count(input count_type c);
      count_type r;
      if (c == 6'd0) begin
         r = 6'd1;
      end else if (c > MAX_WORDS) begin
         r = MAX_WORDS;
      end else begin
         r = c;
      end
      return r;
   endfunction

   function automatic word_type crc_byte(input word_type crc, input byte_type b);
      word_type c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// File: src/mbm_req_if.sv
// Request channel: commands, write words and received bytes.
interface mbm_req_if import mbm_pkg::*; ();
   logic        valid;
   logic        ready;
   command_type command;
   word_type    data;

   modport source (output valid, command, data, input ready);
   modport sink (input valid, command, data, output ready);
endinterface

// File: src/mbm_rsp_if.sv
// Result channel: transmit bytes, register words read and write acknowledges.
interface mbm_rsp_if import mbm_pkg::*; ();
   logic      valid;
   logic      ready;
   kind_type  kind;
   word_type  value;
   count_type word_index;
   logic      last;
   word_type  error_count;

   modport source (output valid, kind, value, word_index, last, error_count, input ready);
   modport sink (input valid, kind, value, word_index, last, error_count, output ready);
endinterface

// File: src/mbm_csr_if.sv
// Configuration write channel carrying a register index and write data.
interface mbm_csr_if import mbm_pkg::*; ();
   logic          valid;
   logic          ready;
   reg_index_type index;
   word_type      data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: src/modbus_rtu_master_poll_write_top.sv
// Top level of the Modbus RTU master that polls one slave and writes register blocks.
//
// The req_bus channel takes one command per transfer: start a read poll, supply the next
// word of a multiple-register write, or deliver one byte received from the line.
// The rsp_bus channel returns the bytes to transmit, the register words of a good read
// reply and the write acknowledge, with last set on the final result of each command.
// The csr_bus channel writes the slave address, the read and write start addresses and
// the read and write counts; it is always ready, and the user must write it only while
// idle, as the block does not enforce this. One command is handled at a time and
// req_bus.ready is low while it is worked on. Frame bytes leave at one per cycle while
// rsp_bus takes them, through a CRC unit that folds one byte per cycle.
// A completed read reply is checked in states CHK0 to CHK3 through the single read
// port of the receive buffer, and each register word then takes two buffer reads and
// one output transfer. A write acknowledge is checked in states CHK0 to CHK2 and sent
// from state ACK; a failed check returns to idle early.
// The output register holds a result while the receiver stalls, and the sequencer waits
// for it to drain before it moves on, so no result is lost when rsp_bus.ready is low.
// A synchronous reset restores the register defaults, clears the pending flags, the error
// count and the receive pointer; the receive buffer itself is not cleared.
module modbus_rtu_master_poll_write_top import mbm_pkg::*; #(
   parameter int RX_BUFFER_DEPTH = 128
) (
   input logic       clock,
   input logic       reset,
   mbm_req_if.sink   req_bus,
   mbm_rsp_if.source rsp_bus,
   mbm_csr_if.sink   csr_bus
);

   localparam int AW = $clog2(RX_BUFFER_DEPTH);
   localparam int PW = $clog2(RX_BUFFER_DEPTH + 1);
   localparam int CW = (PW > 8) ? PW : 8;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_TX   = 4'd1;
   localparam logic [3:0] ST_CHK0 = 4'd2;
   localparam logic [3:0] ST_CHK1 = 4'd3;
   localparam logic [3:0] ST_CHK2 = 4'd4;
   localparam logic [3:0] ST_CHK3 = 4'd5;
   localparam logic [3:0] ST_WHI  = 4'd6;
   localparam logic [3:0] ST_WLO  = 4'd7;
   localparam logic [3:0] ST_WOUT = 4'd8;
   localparam logic [3:0] ST_ACK  = 4'd9;

   byte_type  slave_address_ff, slave_address_in;
   word_type  read_start_ff, read_start_in;
   count_type read_count_ff, read_count_in;
   word_type  write_start_ff, write_start_in;
   count_type write_count_ff, write_count_in;

   logic [3:0]    state_ff, state_in;
   step_type      step_ff, step_in;
   logic          is_read_ff, is_read_in;
   logic          final_ff, final_in;
   word_type      data_ff, data_in;
   word_type      crc_ff, crc_in;
   word_type      tx_crc_ff, tx_crc_in;
   word_type      errors_ff, errors_in;
   logic          read_pending_ff, read_pending_in;
   logic          write_pending_ff, write_pending_in;
   count_type     wwn_ff, wwn_in;
   byte_type      exp_ff, exp_in;
   logic [PW-1:0] rx_ptr_ff, rx_ptr_in;
   count_type     word_ff, word_in;
   byte_type      hi_ff, hi_in;

   logic          rsp_valid_ff, rsp_valid_in;
   kind_type      rsp_kind_ff, rsp_kind_in;
   word_type      rsp_value_ff, rsp_value_in;
   count_type     rsp_index_ff, rsp_index_in;
   logic          rsp_last_ff, rsp_last_in;
   word_type      rsp_errors_ff, rsp_errors_in;

   byte_type      rx_bytes_ff [RX_BUFFER_DEPTH];
   byte_type      rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic          mem_we;

   logic          req_accept;
   logic          out_free;
   logic          out_load;
   kind_type      out_kind;
   word_type      out_value;
   count_type     out_index;
   logic          out_last;
   count_type     rd_cnt;
   count_type     wr_cnt;
   count_type     tx_cnt;
   word_type      tx_start;
   byte_type      tx_byte;
   logic          tx_last;
   count_type     wwn_next;
   logic [PW-1:0] ptr_new;
   logic          ptr_room;
   byte_type      exp_less;
   count_type     reply_cnt;
   byte_type      word_hi_addr;
   byte_type      word_lo_addr;
   logic          word_last;

   assign req_bus.ready       = (state_ff == ST_IDLE);
   assign req_accept          = req_bus.valid && req_bus.ready;
   assign csr_bus.ready       = 1'b1;
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.kind        = rsp_kind_ff;
   assign rsp_bus.value       = rsp_value_ff;
   assign rsp_bus.word_index  = rsp_index_ff;
   assign rsp_bus.last        = rsp_last_ff;
   assign rsp_bus.error_count = rsp_errors_ff;

   assign rd_cnt       = sat_count(read_count_ff);
   assign wr_cnt       = sat_count(write_count_ff);
   assign tx_cnt       = is_read_ff ? rd_cnt : wr_cnt;
   assign tx_start     = is_read_ff ? read_start_ff : write_start_ff;
   assign wwn_next     = wwn_ff + 6'd1;
   assign ptr_room     = (rx_ptr_ff < PW'(RX_BUFFER_DEPTH));
   assign ptr_new      = ptr_room ? (rx_ptr_ff + PW'(1)) : rx_ptr_ff;
   assign exp_less     = exp_ff - 8'd5;
   assign reply_cnt    = exp_less[6:1];
   assign word_hi_addr = 8'd3 + {1'b0, word_ff, 1'b0};
   assign word_lo_addr = 8'd4 + {1'b0, word_ff, 1'b0};
   assign word_last    = (word_ff == (reply_cnt - 6'd1));

   always_comb begin
      unique case (step_ff)
         STEP_ADDR:     tx_byte = slave_address_ff;
         STEP_FUNC:     tx_byte = is_read_ff ? FN_READ : FN_WRITE;
         STEP_START_HI: tx_byte = tx_start[15:8];
         STEP_START_LO: tx_byte = tx_start[7:0];
         STEP_CNT_HI:   tx_byte = 8'h00;
         STEP_CNT_LO:   tx_byte = {2'b00, tx_cnt};
         STEP_BYTES:    tx_byte = {1'b0, tx_cnt, 1'b0};
         STEP_DATA_HI:  tx_byte = data_ff[15:8];
         STEP_DATA_LO:  tx_byte = data_ff[7:0];
         STEP_CRC_LO:   tx_byte = crc_ff[7:0];
         STEP_CRC_HI:   tx_byte = crc_ff[15:8];
         default:       tx_byte = 8'h00;
      endcase
      tx_last = (step_ff == STEP_CRC_HI) ||
                (!is_read_ff && (step_ff == STEP_DATA_LO) && !final_ff);
   end

   always_comb begin
      slave_address_in = slave_address_ff;
      read_start_in    = read_start_ff;
      read_count_in    = read_count_ff;
      write_start_in   = write_start_ff;
      write_count_in   = write_count_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            REG_SLAVE_ADDRESS: slave_address_in = csr_bus.data[7:0];
            REG_READ_START:    read_start_in    = csr_bus.data;
            REG_READ_COUNT:    read_count_in    = csr_bus.data[5:0];
            REG_WRITE_START:   write_start_in   = csr_bus.data;
            REG_WRITE_COUNT:   write_count_in   = csr_bus.data[5:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in         = state_ff;
      step_in          = step_ff;
      is_read_in       = is_read_ff;
      final_in         = final_ff;
      data_in          = data_ff;
      crc_in           = crc_ff;
      tx_crc_in        = tx_crc_ff;
      errors_in        = errors_ff;
      read_pending_in  = read_pending_ff;
      write_pending_in = write_pending_ff;
      wwn_in           = wwn_ff;
      exp_in           = exp_ff;
      rx_ptr_in        = rx_ptr_ff;
      word_in          = word_ff;
      hi_in            = hi_ff;
      out_free         = !rsp_valid_ff || rsp_bus.ready;
      out_load         = 1'b0;
      out_kind         = KIND_TX;
      out_value        = '0;
      out_index        = '0;
      out_last         = 1'b0;
      mem_we           = 1'b0;
      rd_addr          = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               is_read_in = (req_bus.command == CMD_READ);
               data_in    = req_bus.data;
               unique case (req_bus.command)
                  CMD_READ: begin
                     if (!write_pending_ff && (wwn_ff == 6'd0)) begin
                        if (read_pending_ff) begin
                           errors_in = errors_ff + 16'd1;
                        end
                        rx_ptr_in       = '0;
                        read_pending_in = 1'b1;
                        crc_in          = CRC_INIT;
                        exp_in          = {1'b0, rd_cnt, 1'b0} + 8'd5;
                        step_in         = STEP_ADDR;
                        state_in        = ST_TX;
                     end
                  end
                  CMD_WRITE: begin
                     if ((wwn_ff != 6'd0) || !read_pending_ff) begin
                        if (wwn_ff == 6'd0) begin
                           if (write_pending_ff) begin
                              errors_in = errors_ff + 16'd1;
                           end
                           crc_in  = CRC_INIT;
                           step_in = STEP_ADDR;
                        end else begin
                           crc_in  = tx_crc_ff;
                           step_in = STEP_DATA_HI;
                        end
                        state_in = ST_TX;
                        final_in = (wwn_next >= wr_cnt);
                        if (wwn_next >= wr_cnt) begin
                           wwn_in           = '0;
                           exp_in           = ACK_LENGTH;
                           rx_ptr_in        = '0;
                           write_pending_in = 1'b1;
                        end else begin
                           wwn_in = wwn_next;
                        end
                     end
                  end
                  CMD_RX: begin
                     mem_we    = ptr_room;
                     rx_ptr_in = ptr_new;
                     if ((CW'(ptr_new) >= CW'(exp_ff)) &&
                         (read_pending_ff || write_pending_ff)) begin
                        state_in = ST_CHK0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_TX: begin
            if (out_free) begin
               out_load  = 1'b1;
               out_value = {8'h00, tx_byte};
               out_last  = tx_last;
               if (step_ff < STEP_CRC_LO) begin
                  crc_in = crc_byte(crc_ff, tx_byte);
               end
               if (!is_read_ff && (step_ff == STEP_DATA_LO)) begin
                  tx_crc_in = crc_in;
               end
               if (tx_last) begin
                  state_in = ST_IDLE;
               end else if (is_read_ff && (step_ff == STEP_CNT_LO)) begin
                  step_in = STEP_CRC_LO;
               end else begin
                  step_in = step_ff + 4'd1;
               end
            end
         end
         ST_CHK0: begin
            rd_addr  = AW'(0);
            state_in = ST_CHK1;
         end
         ST_CHK1: begin
            rd_addr  = AW'(1);
            state_in = (rd_data_ff == slave_address_ff) ? ST_CHK2 : ST_IDLE;
         end
         ST_CHK2: begin
            rd_addr = AW'(2);
            if (rd_data_ff != (read_pending_ff ? FN_READ : FN_WRITE)) begin
               state_in = ST_IDLE;
            end else begin
               state_in = read_pending_ff ? ST_CHK3 : ST_ACK;
            end
         end
         ST_CHK3: begin
            word_in = '0;
            if (rd_data_ff == {exp_less[7:1], 1'b0}) begin
               state_in = ST_WHI;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_WHI: begin
            rd_addr  = word_hi_addr[AW-1:0];
            state_in = ST_WLO;
         end
         ST_WLO: begin
            rd_addr  = word_lo_addr[AW-1:0];
            hi_in    = rd_data_ff;
            state_in = ST_WOUT;
         end
         ST_WOUT: begin
            rd_addr = word_lo_addr[AW-1:0];
            if (out_free) begin
               out_load  = 1'b1;
               out_kind  = KIND_WORD;
               out_value = {hi_ff, rd_data_ff};
               out_index = word_ff;
               out_last  = word_last;
               if (word_last) begin
                  read_pending_in = 1'b0;
                  rx_ptr_in       = '0;
                  state_in        = ST_IDLE;
               end else begin
                  word_in  = word_ff + 6'd1;
                  state_in = ST_WHI;
               end
            end
         end
         ST_ACK: begin
            if (out_free) begin
               out_load         = 1'b1;
               out_kind         = KIND_ACK;
               out_last         = 1'b1;
               write_pending_in = 1'b0;
               rx_ptr_in        = '0;
               state_in         = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      rsp_kind_in   = out_load ? out_kind : rsp_kind_ff;
      rsp_value_in  = out_load ? out_value : rsp_value_ff;
      rsp_index_in  = out_load ? out_index : rsp_index_ff;
      rsp_last_in   = out_load ? out_last : rsp_last_ff;
      rsp_errors_in = out_load ? errors_ff : rsp_errors_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         rx_bytes_ff[rx_ptr_ff[AW-1:0]] <= req_bus.data[7:0];
      end
      rd_data_ff <= rx_bytes_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_address_ff <= 8'd1;
         read_start_ff    <= 16'd0;
         read_count_ff    <= 6'd40;
         write_start_ff   <= 16'd1000;
         write_count_ff   <= 6'd20;
         state_ff         <= ST_IDLE;
         crc_ff           <= CRC_INIT;
         tx_crc_ff        <= CRC_INIT;
         errors_ff        <= '0;
         read_pending_ff  <= 1'b0;
         write_pending_ff <= 1'b0;
         wwn_ff           <= '0;
         exp_ff           <= 8'd85;
         rx_ptr_ff        <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         slave_address_ff <= slave_address_in;
         read_start_ff    <= read_start_in;
         read_count_ff    <= read_count_in;
         write_start_ff   <= write_start_in;
         write_count_ff   <= write_count_in;
         state_ff         <= state_in;
         crc_ff           <= crc_in;
         tx_crc_ff        <= tx_crc_in;
         errors_ff        <= errors_in;
         read_pending_ff  <= read_pending_in;
         write_pending_ff <= write_pending_in;
         wwn_ff           <= wwn_in;
         exp_ff           <= exp_in;
         rx_ptr_ff        <= rx_ptr_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff       <= step_in;
      is_read_ff    <= is_read_in;
      final_ff      <= final_in;
      data_ff       <= data_in;
      word_ff       <= word_in;
      hi_ff         <= hi_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_errors_ff <= rsp_errors_in;
   end

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the Modbus RTU poll-and-write master: frames, replies and stalls.
`timescale 1ns / 1ps

module tb_top;
   import mbm_pkg::*;

   localparam int          RX_DEPTH           = 128;
   localparam int          SETTLE_CYCLES      = 24;
   localparam int          HOLD_AFTER_RESULTS = 200;
   localparam int          LONG_HOLD_CYCLES   = 300;
   localparam int          PHASE_ITEMS        = 20;
   localparam int          RANDOM_PHASES      = 3;
   localparam longint      TIME_LIMIT_NS      = 64'd30_000_000;
   localparam command_type CMD_UNKNOWN        = 2'd3;

   typedef enum int unsigned {
      FLAW_NONE,
      FLAW_STATION,
      FLAW_FUNCTION,
      FLAW_COUNT
   } reply_flaw_type;

   typedef struct packed {
      command_type command;
      word_type    data;
   } master_cmd_type;

   typedef struct packed {
      kind_type  kind;
      word_type  value;
      count_type word_index;
      logic      last;
      word_type  error_count;
   } master_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic          offer_valid   = 1'b0;
   command_type   offer_command = CMD_READ;
   word_type      offer_data    = '0;
   logic          take_ready    = 1'b0;
   logic          reg_valid     = 1'b0;
   reg_index_type reg_index     = REG_SLAVE_ADDRESS;
   word_type      reg_data      = '0;

   mbm_req_if req_if ();
   mbm_rsp_if rsp_if ();
   mbm_csr_if csr_if ();

   assign req_if.valid   = offer_valid;
   assign req_if.command = offer_command;
   assign req_if.data    = offer_data;
   assign rsp_if.ready   = take_ready;
   assign csr_if.valid   = reg_valid;
   assign csr_if.index   = reg_index;
   assign csr_if.data    = reg_data;

   modbus_rtu_master_poll_write_top #(
      .RX_BUFFER_DEPTH(RX_DEPTH)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_if),
      .rsp_bus(rsp_if),
      .csr_bus(csr_if)
   );

   master_cmd_type    command_backlog [$];
   master_result_type awaited_results [$];
   master_result_type step_results [$];

   byte_type    cfg_station     = 8'd1;
   word_type    cfg_poll_start  = 16'd0;
   count_type   cfg_poll_count  = 6'd40;
   word_type    cfg_block_start = 16'd1000;
   count_type   cfg_block_count = 6'd20;

   byte_type    rx_store [RX_DEPTH];
   int unsigned rx_fill      = 0;
   int unsigned reply_length = 85;
   logic        poll_open    = 1'b0;
   logic        ack_open     = 1'b0;
   count_type   frame_words  = '0;
   word_type    frame_crc    = CRC_INIT;
   word_type    error_tally  = '0;

   int unsigned failures      = 0;
   int unsigned phase_items   = 0;
   int unsigned results_taken = 0;
   int unsigned source_wait   = 0;
   int unsigned sink_wait     = 0;
   bit          source_calm   = 1'b0;
   bit          sink_calm     = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic count_type clamp_words(input count_type c);
      count_type r;
      r = c;
      if (c == 6'd0) begin
         r = 6'd1;
      end else if (c > MAX_WORDS) begin
         r = MAX_WORDS;
      end
      return r;
   endfunction

   function automatic word_type crc16_fold(input word_type crc, input byte_type b);
      word_type acc;
      acc = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (acc[0]) begin
            acc = (acc >> 1) ^ CRC_POLY;
         end else begin
            acc = acc >> 1;
         end
      end
      return acc;
   endfunction

   task automatic add_result(input kind_type k, input word_type v, input count_type idx);
      master_result_type r;
      r.kind        = k;
      r.value       = v;
      r.word_index  = idx;
      r.last        = 1'b0;
      r.error_count = '0;
      step_results.push_back(r);
   endtask

   task automatic send_frame_byte(input byte_type b);
      frame_crc = crc16_fold(frame_crc, b);
      add_result(KIND_TX, {8'h00, b}, '0);
   endtask

   task automatic model_command(input command_type cmd, input word_type data);
      master_result_type r;
      count_type         n;
      word_type          keep_crc;
      word_type          crc_out;
      step_results.delete();
      case (cmd)
         CMD_READ: begin
            n = clamp_words(cfg_poll_count);
            if (!ack_open && frame_words == 6'd0) begin
               if (poll_open) begin
                  error_tally = error_tally + 16'd1;
               end
               keep_crc  = frame_crc;
               rx_fill   = 0;
               poll_open = 1'b1;
               frame_crc = CRC_INIT;
               send_frame_byte(cfg_station);
               send_frame_byte(FN_READ);
               send_frame_byte(cfg_poll_start[15:8]);
               send_frame_byte(cfg_poll_start[7:0]);
               send_frame_byte(8'h00);
               send_frame_byte({2'b00, n});
               crc_out = frame_crc;
               add_result(KIND_TX, {8'h00, crc_out[7:0]}, '0);
               add_result(KIND_TX, {8'h00, crc_out[15:8]}, '0);
               frame_crc    = keep_crc;
               reply_length = 2 * n + 5;
            end
         end
         CMD_WRITE: begin
            n = clamp_words(cfg_block_count);
            if (frame_words != 6'd0 || !poll_open) begin
               if (frame_words == 6'd0) begin
                  if (ack_open) begin
                     error_tally = error_tally + 16'd1;
                  end
                  frame_crc = CRC_INIT;
                  send_frame_byte(cfg_station);
                  send_frame_byte(FN_WRITE);
                  send_frame_byte(cfg_block_start[15:8]);
                  send_frame_byte(cfg_block_start[7:0]);
                  send_frame_byte(8'h00);
                  send_frame_byte({2'b00, n});
                  send_frame_byte(byte_type'(2 * n));
               end
               send_frame_byte(data[15:8]);
               send_frame_byte(data[7:0]);
               frame_words = frame_words + 6'd1;
               if (frame_words >= n) begin
                  crc_out = frame_crc;
                  add_result(KIND_TX, {8'h00, crc_out[7:0]}, '0);
                  add_result(KIND_TX, {8'h00, crc_out[15:8]}, '0);
                  frame_words  = '0;
                  frame_crc    = CRC_INIT;
                  reply_length = ACK_LENGTH;
                  rx_fill      = 0;
                  ack_open     = 1'b1;
               end
            end
         end
         CMD_RX: begin
            if (rx_fill < RX_DEPTH) begin
               rx_store[rx_fill] = data[7:0];
               rx_fill++;
            end
            if (rx_fill >= reply_length) begin
               if (poll_open) begin
                  n = count_type'((reply_length - 5) / 2);
                  if (rx_store[0] == cfg_station && rx_store[1] == FN_READ &&
                      rx_store[2] == byte_type'(2 * n)) begin
                     for (int i = 0; i < n; i++) begin
                        add_result(KIND_WORD, {rx_store[3 + 2 * i], rx_store[4 + 2 * i]},
                                   count_type'(i));
                     end
                     poll_open = 1'b0;
                     rx_fill   = 0;
                  end
               end
               if (ack_open && rx_store[0] == cfg_station && rx_store[1] == FN_WRITE) begin
                  add_result(KIND_ACK, '0, '0);
                  ack_open = 1'b0;
                  rx_fill  = 0;
               end
            end
         end
         default: begin
         end
      endcase
      for (int i = 0; i < step_results.size(); i++) begin
         r             = step_results[i];
         r.last        = (i == step_results.size() - 1);
         r.error_count = error_tally;
         awaited_results.push_back(r);
      end
   endtask

   task automatic flag_mismatch(input string what, input word_type got, input word_type want);
      failures++;
      $display("MISMATCH at %0t ns: %s got 0x%0h expected 0x%0h", $time, what, got, want);
   endtask

   always @(posedge clock) begin
      master_cmd_type next;
      if (reset) begin
         offer_valid <= 1'b0;
      end else begin
         if (offer_valid && req_if.ready) begin
            model_command(offer_command, offer_data);
         end
         if (!offer_valid || req_if.ready) begin
            if (source_wait != 0) begin
               source_wait--;
               offer_valid <= 1'b0;
            end else if (command_backlog.size() != 0) begin
               next = command_backlog.pop_front();
               offer_valid   <= 1'b1;
               offer_command <= next.command;
               offer_data    <= next.data;
               if ($urandom_range(0, 31) == 0) begin
                  source_calm = !source_calm;
               end
               source_wait = source_calm ? 0 : $urandom_range(0, 13);
            end else begin
               offer_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         take_ready <= 1'b0;
      end else if (rsp_if.valid && take_ready) begin
         results_taken++;
         if ($urandom_range(0, 31) == 0) begin
            sink_calm = !sink_calm;
         end
         sink_wait = sink_calm ? 0 : $urandom_range(0, 13);
         if (results_taken == HOLD_AFTER_RESULTS) begin
            sink_wait = LONG_HOLD_CYCLES;
         end
         take_ready <= (sink_wait == 0);
      end else if (sink_wait != 0) begin
         sink_wait--;
         take_ready <= (sink_wait == 0);
      end else begin
         take_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      master_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (awaited_results.size() == 0) begin
            flag_mismatch("result with nothing awaited, value", rsp_if.value, '0);
         end else begin
            want = awaited_results.pop_front();
            if (rsp_if.kind !== want.kind) begin
               flag_mismatch("kind", rsp_if.kind, want.kind);
            end
            if (rsp_if.value !== want.value) begin
               flag_mismatch("value", rsp_if.value, want.value);
            end
            if (rsp_if.word_index !== want.word_index) begin
               flag_mismatch("word_index", rsp_if.word_index, want.word_index);
            end
            if (rsp_if.last !== want.last) begin
               flag_mismatch("last", rsp_if.last, want.last);
            end
            if (rsp_if.error_count !== want.error_count) begin
               flag_mismatch("error_count", rsp_if.error_count, want.error_count);
            end
         end
      end
   end

   task automatic queue_item(input command_type c, input word_type d);
      master_cmd_type item;
      item.command = c;
      item.data    = d;
      command_backlog.push_back(item);
      phase_items++;
   endtask

   task automatic queue_rx(input byte_type b);
      word_type w;
      w      = word_type'($urandom_range(0, 65535));
      w[7:0] = b;
      queue_item(CMD_RX, w);
   endtask

   task automatic queue_poll(input bit twice);
      queue_item(CMD_READ, word_type'($urandom_range(0, 65535)));
      if (twice) begin
         queue_item(CMD_READ, word_type'($urandom_range(0, 65535)));
      end
   endtask

   task automatic queue_poll_reply(input reply_flaw_type flaw, input int delta);
      byte_type  hdr [3];
      count_type n;
      int        total;
      n      = clamp_words(cfg_poll_count);
      hdr[0] = cfg_station;
      hdr[1] = FN_READ;
      hdr[2] = byte_type'(2 * n);
      case (flaw)
         FLAW_STATION:  hdr[0] = hdr[0] ^ byte_type'($urandom_range(1, 255));
         FLAW_FUNCTION: hdr[1] = hdr[1] ^ byte_type'($urandom_range(1, 255));
         FLAW_COUNT:    hdr[2] = hdr[2] ^ byte_type'($urandom_range(1, 255));
         default: begin
         end
      endcase
      total = 2 * n + 5 + delta;
      for (int i = 0; i < total; i++) begin
         queue_rx(i < 3 ? hdr[i] : byte_type'($urandom_range(0, 255)));
      end
   endtask

   task automatic queue_write_ack(input reply_flaw_type flaw);
      byte_type station;
      byte_type func;
      station = cfg_station;
      func    = FN_WRITE;
      if (flaw == FLAW_STATION) begin
         station = station ^ byte_type'($urandom_range(1, 255));
      end else if (flaw == FLAW_FUNCTION) begin
         func = func ^ byte_type'($urandom_range(1, 255));
      end
      queue_rx(station);
      queue_rx(func);
      for (int i = 0; i < ACK_LENGTH - 2; i++) begin
         queue_rx(byte_type'($urandom_range(0, 255)));
      end
   endtask

   task automatic queue_write_words(input int count);
      for (int i = 0; i < count; i++) begin
         queue_item(CMD_WRITE, word_type'($urandom_range(0, 65535)));
      end
   endtask

   task automatic wait_until_drained();
      do begin
         @(posedge clock);
      end while (command_backlog.size() != 0 || offer_valid || awaited_results.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input reg_index_type idx, input word_type value);
      @(posedge clock);
      reg_valid <= 1'b1;
      reg_index <= idx;
      reg_data  <= value;
      do begin
         @(posedge clock);
      end while (!csr_if.ready);
      reg_valid <= 1'b0;
      case (idx)
         REG_SLAVE_ADDRESS: cfg_station     = value[7:0];
         REG_READ_START:    cfg_poll_start  = value;
         REG_READ_COUNT:    cfg_poll_count  = value[5:0];
         REG_WRITE_START:   cfg_block_start = value;
         REG_WRITE_COUNT:   cfg_block_count = value[5:0];
         default: begin
         end
      endcase
   endtask

   function automatic word_type random_count_word();
      word_type w;
      w = word_type'($urandom_range(0, 65535));
      if ($urandom_range(0, 7) == 0) begin
         w[5:0] = 6'd0;
      end else begin
         w[5:0] = count_type'($urandom_range(1, 5));
      end
      return w;
   endfunction

   task automatic pick_settings();
      word_type w;
      w = word_type'($urandom_range(0, 65535));
      if ($urandom_range(0, 9) == 0) begin
         w[7:0] = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
      end else begin
         w[7:0] = byte_type'($urandom_range(1, 247));
      end
      write_register(REG_SLAVE_ADDRESS, w);
      write_register(REG_READ_START, word_type'($urandom_range(0, 65535)));
      write_register(REG_READ_COUNT, random_count_word());
      write_register(REG_WRITE_START, word_type'($urandom_range(0, 65535)));
      write_register(REG_WRITE_COUNT, random_count_word());
   endtask

   task automatic run_scenario();
      int unsigned    pick;
      int             words;
      int             split;
      reply_flaw_type flaw;
      pick  = $urandom_range(0, 99);
      words = clamp_words(cfg_block_count);
      if (pick < 30) begin
         queue_poll(1'b0);
         queue_poll_reply(FLAW_NONE, 0);
      end else if (pick < 48) begin
         queue_write_words(words);
         queue_write_ack(FLAW_NONE);
      end else if (pick < 58) begin
         flaw = reply_flaw_type'($urandom_range(0, 3));
         queue_poll(1'b0);
         queue_poll_reply(flaw, (flaw == FLAW_NONE) ? -int'($urandom_range(1, 4)) : 0);
      end else if (pick < 65) begin
         queue_write_words(words);
         queue_write_ack(reply_flaw_type'($urandom_range(1, 2)));
         queue_write_words(words);
         queue_write_ack(FLAW_NONE);
      end else if (pick < 72) begin
         split = $urandom_range(1, words);
         queue_write_words(split);
         queue_poll(1'b0);
         queue_write_words(words - split);
         queue_write_ack(FLAW_NONE);
      end else if (pick < 79) begin
         queue_poll(1'b0);
         queue_write_words(1);
         queue_poll_reply(FLAW_NONE, 0);
      end else if (pick < 85) begin
         queue_poll(1'b1);
         queue_poll_reply(FLAW_NONE, 0);
      end else if (pick < 88) begin
         queue_write_words(words);
         queue_write_words(words);
         queue_write_ack(FLAW_NONE);
      end else if (pick < 95) begin
         repeat ($urandom_range(1, 6)) begin
            queue_item(command_type'($urandom_range(0, 3)),
                       word_type'($urandom_range(0, 65535)));
         end
      end else begin
         wait_until_drained();
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      queue_item(CMD_READ, 16'h0000);
      queue_item(CMD_WRITE, 16'hFFFF);
      queue_item(CMD_READ, 16'hFFFF);
      queue_item(CMD_UNKNOWN, 16'hFFFF);
      wait_until_drained();
      write_register(REG_READ_COUNT, 16'hFFC1);
      queue_item(CMD_READ, 16'h5A5A);
      queue_rx(cfg_station);
      queue_rx(FN_READ);
      queue_rx(8'h02);
      queue_rx(8'hFF);
      queue_rx(8'h00);
      queue_rx(8'hA5);
      queue_rx(8'h5A);
      queue_item(CMD_WRITE, 16'h0000);
      queue_item(CMD_READ, 16'h0000);
      wait_until_drained();
      write_register(REG_WRITE_COUNT, 16'h0000);
      queue_item(CMD_WRITE, 16'hFFFF);
      queue_item(CMD_READ, 16'h0000);
      queue_write_ack(FLAW_NONE);
      wait_until_drained();

      write_register(REG_SLAVE_ADDRESS, {byte_type'($urandom_range(0, 255)), 8'd247});
      write_register(REG_READ_START, 16'hFFFF);
      write_register(REG_READ_COUNT, 16'h003F);
      write_register(REG_WRITE_START, 16'h0000);
      write_register(REG_WRITE_COUNT, 16'hFFBC);
      queue_poll(1'b0);
      queue_poll_reply(FLAW_STATION, 5);
      queue_poll(1'b0);
      queue_poll_reply(FLAW_NONE, 0);
      queue_write_words(MAX_WORDS);
      queue_write_ack(FLAW_NONE);
      wait_until_drained();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         pick_settings();
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            run_scenario();
         end
         wait_until_drained();
      end

      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #(TIME_LIMIT_NS);
      $display("Test completed with failures");
      $finish;
   end

endmodule
